// ===== hw/rtl/chp_pkg.sv =====
// Shared types, constants and register indexes for the core hotplug policy block.
package chp_pkg;

  localparam int unsigned NUM_CORES = 4;
  localparam int unsigned LOAD_W    = 7;
  localparam int unsigned FREQ_W    = 22;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned PRESS_W   = 5;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned SUM_W     = 9;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned PROD_W    = 10;

  localparam logic [PRESS_W-1:0] COUNTER_CAP = 5'd25;
  localparam logic [PRESS_W-1:0] UP_LEVEL    = 5'd10;
  localparam logic [LOAD_W-1:0]  FULL_LOAD   = 7'd100;

  localparam logic [NUM_CORES-1:0] ALL_ONLINE = 4'hF;

  localparam logic [LOAD_W-1:0]  RST_SINGLE_THR = 7'd90;
  localparam logic [LOAD_W-1:0]  RST_AVG_THR    = 7'd70;
  localparam logic [FREQ_W-1:0]  RST_UP_FREQ    = 22'd1100000;
  localparam logic               RST_BOOST_EN   = 1'b0;
  localparam logic               RST_SAVER_EN   = 1'b1;
  localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SINGLE_THR = 3'd0,
    CFG_AVG_THR    = 3'd1,
    CFG_UP_FREQ    = 3'd2,
    CFG_BOOST_EN   = 3'd3,
    CFG_SAVER_EN   = 3'd4,
    CFG_HOLD_TICKS = 3'd5
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_SCREEN_OFF = 2'd1,
    OP_SCREEN_ON  = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CNT,
    ST_DEC,
    ST_DOWN,
    ST_EVT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic cnt;
    logic dec;
    logic down;
    logic evt;
    logic out_load;
    logic part;
  } cmd_t;

  typedef struct packed {
    logic up_hit;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/chp_ctrl.sv =====
// Hotplug sequencer: a tick walks both core pairs; each request loads a result.
module chp_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [chp_pkg::OP_W-1:0]         in_opcode,
  output logic                             in_ready,
  input  chp_pkg::sts_t                    sts,
  output chp_pkg::cmd_t                    cmd
);

  chp_pkg::state_t state_r, state_nxt;
  logic            part_r, part_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chp_pkg::ST_IDLE;
      part_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      part_r  <= part_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    part_nxt  = part_r;
    unique case (state_r)
      chp_pkg::ST_IDLE: begin
        if (in_valid) begin
          part_nxt = 1'b0;
          if (in_opcode == chp_pkg::OP_TICK) begin
            state_nxt = chp_pkg::ST_SUM;
          end else begin
            state_nxt = chp_pkg::ST_EVT;
          end
        end
      end
      chp_pkg::ST_SUM: state_nxt = chp_pkg::ST_CNT;
      chp_pkg::ST_CNT: state_nxt = chp_pkg::ST_DEC;
      chp_pkg::ST_DEC: begin
        if (!sts.up_hit) begin
          state_nxt = chp_pkg::ST_DOWN;
        end else if (part_r) begin
          state_nxt = chp_pkg::ST_OUT;
        end else begin
          part_nxt  = 1'b1;
          state_nxt = chp_pkg::ST_SUM;
        end
      end
      chp_pkg::ST_DOWN: begin
        if (part_r) begin
          state_nxt = chp_pkg::ST_OUT;
        end else begin
          part_nxt  = 1'b1;
          state_nxt = chp_pkg::ST_SUM;
        end
      end
      chp_pkg::ST_EVT: state_nxt = chp_pkg::ST_OUT;
      chp_pkg::ST_OUT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          state_nxt = chp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.part = part_r;
    in_ready = 1'b0;
    unique case (state_r)
      chp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      chp_pkg::ST_SUM:  cmd.sum  = 1'b1;
      chp_pkg::ST_CNT:  cmd.cnt  = 1'b1;
      chp_pkg::ST_DEC:  cmd.dec  = 1'b1;
      chp_pkg::ST_DOWN: cmd.down = 1'b1;
      chp_pkg::ST_EVT:  cmd.evt  = 1'b1;
      chp_pkg::ST_OUT:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/chp_dp.sv =====
// Datapath for the hotplug policy: config registers, policy state and result register.
module chp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [chp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [chp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [chp_pkg::OP_W-1:0]          in_opcode,
  input  logic [chp_pkg::TIME_W-1:0]        in_now_ticks,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c0,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c1,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c2,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c3,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c0,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c1,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c2,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c3,
  input  chp_pkg::cmd_t                     cmd,
  output chp_pkg::sts_t                     sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [chp_pkg::NUM_CORES-1:0]     out_online_mask,
  output logic [chp_pkg::NUM_CORES-1:0]     out_up_mask,
  output logic [chp_pkg::NUM_CORES-1:0]     out_down_mask,
  output logic [chp_pkg::PRESS_W-1:0]       out_pressure_a,
  output logic [chp_pkg::PRESS_W-1:0]       out_pressure_b
);

  // configuration
  logic [chp_pkg::LOAD_W-1:0] single_thr_r, avg_thr_r;
  logic [chp_pkg::FREQ_W-1:0] up_freq_r;
  logic                       boost_en_r, saver_en_r;
  logic [chp_pkg::HOLD_W-1:0] hold_r;

  // latched request
  logic [chp_pkg::OP_W-1:0]   op_r;
  logic [chp_pkg::TIME_W-1:0] now_r;
  logic [chp_pkg::LOAD_W-1:0] ld_r [chp_pkg::NUM_CORES];
  logic [chp_pkg::FREQ_W-1:0] fq_r [chp_pkg::NUM_CORES];

  // policy state
  logic [chp_pkg::NUM_CORES-1:0] online_r, online_nxt;
  logic [chp_pkg::NUM_CORES-1:0] before_r;
  logic [chp_pkg::PRESS_W-1:0]   press_r [2];
  logic [chp_pkg::PRESS_W-1:0]   press_nxt [2];
  logic [chp_pkg::TIME_W-1:0]    last_r, last_nxt;
  logic [chp_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [chp_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [chp_pkg::TIME_W-1:0]    elapsed_r, elapsed_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [chp_pkg::NUM_CORES-1:0] out_online_r, out_up_r, out_down_r;
  logic [chp_pkg::PRESS_W-1:0]   out_pa_r, out_pb_r;

  logic                          out_free;
  logic [chp_pkg::LOAD_W-1:0]    ld_p;
  logic [chp_pkg::FREQ_W-1:0]    fq_p;
  logic [chp_pkg::PRESS_W-1:0]   press_p;
  logic [1:0]                    child;
  logic                          up_ok_child;
  logic                          up_hit;

  assign out_free    = !out_valid_r || out_ready;
  assign ld_p        = ld_r[{1'b0, cmd.part}];
  assign fq_p        = fq_r[{1'b0, cmd.part}];
  assign press_p     = press_r[cmd.part];
  assign child       = {1'b1, cmd.part};
  assign up_ok_child = !online_r[child] && (online_r != chp_pkg::ALL_ONLINE);
  assign up_hit      = press_p >= chp_pkg::UP_LEVEL;

  assign sts.up_hit   = up_hit;
  assign sts.out_free = out_free;

  function automatic logic [chp_pkg::CNT_W-1:0] CNT_ones(
    input logic [chp_pkg::NUM_CORES-1:0] bits
  );
    CNT_ones = {2'b00, bits[0]} + {2'b00, bits[1]} + {2'b00, bits[2]} + {2'b00, bits[3]};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_thr_r <= chp_pkg::RST_SINGLE_THR;
      avg_thr_r    <= chp_pkg::RST_AVG_THR;
      up_freq_r    <= chp_pkg::RST_UP_FREQ;
      boost_en_r   <= chp_pkg::RST_BOOST_EN;
      saver_en_r   <= chp_pkg::RST_SAVER_EN;
      hold_r       <= chp_pkg::RST_HOLD_TICKS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        chp_pkg::CFG_SINGLE_THR: single_thr_r <= cfg_wdata[chp_pkg::LOAD_W-1:0];
        chp_pkg::CFG_AVG_THR:    avg_thr_r    <= cfg_wdata[chp_pkg::LOAD_W-1:0];
        chp_pkg::CFG_UP_FREQ:    up_freq_r    <= cfg_wdata[chp_pkg::FREQ_W-1:0];
        chp_pkg::CFG_BOOST_EN:   boost_en_r   <= cfg_wdata[0];
        chp_pkg::CFG_SAVER_EN:   saver_en_r   <= cfg_wdata[0];
        chp_pkg::CFG_HOLD_TICKS: hold_r       <= cfg_wdata[chp_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      now_r    <= in_now_ticks;
      ld_r[0]  <= in_load_c0;
      ld_r[1]  <= in_load_c1;
      ld_r[2]  <= in_load_c2;
      ld_r[3]  <= in_load_c3;
      fq_r[0]  <= in_freq_c0;
      fq_r[1]  <= in_freq_c1;
      fq_r[2]  <= in_freq_c2;
      fq_r[3]  <= in_freq_c3;
      before_r <= online_r;
    end
    sum_r     <= sum_nxt;
    n_r       <= n_nxt;
    elapsed_r <= elapsed_nxt;
    if (cmd.out_load) begin
      out_online_r <= online_r;
      out_up_r     <= online_r & ~before_r;
      out_down_r   <= before_r & ~online_r;
      out_pa_r     <= press_r[0];
      out_pb_r     <= press_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r    <= chp_pkg::ALL_ONLINE;
      press_r[0]  <= '0;
      press_r[1]  <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      online_r    <= online_nxt;
      press_r[0]  <= press_nxt[0];
      press_r[1]  <= press_nxt[1];
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    logic [chp_pkg::PROD_W-1:0] thr_prod;
    logic [chp_pkg::PROD_W-1:0] full_prod;
    logic                       avg_full;
    logic                       avg_ok;
    logic [chp_pkg::TIME_W-1:0] diff;
    logic                       skip;
    logic                       block;
    logic [1:0]                 tgt;
    logic [chp_pkg::LOAD_W-1:0] lowest;

    online_nxt    = online_r;
    press_nxt[0]  = press_r[0];
    press_nxt[1]  = press_r[1];
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r;

    thr_prod  = {3'b000, avg_thr_r} * {7'b0000000, n_r};
    full_prod = {3'b000, chp_pkg::FULL_LOAD} * {7'b0000000, n_r};
    avg_full  = (n_r != '0) && ({1'b0, sum_r} >= full_prod);
    avg_ok    = (n_r == '0) ? (avg_thr_r == '0) : ({1'b0, sum_r} >= thr_prod);

    diff = elapsed_r - {{(chp_pkg::TIME_W-chp_pkg::HOLD_W){1'b0}}, hold_r};
    skip = cmd.part ? !online_r[3] : (!online_r[2] && (!online_r[3] || !online_r[1]));
    block = (online_r[2] &&
             (((ld_r[2] > ld_r[0]) && (fq_r[2] >= fq_r[0])) ||
              ((ld_r[2] > ld_r[1]) && (fq_r[2] >= fq_r[1])))) ||
            (online_r[3] &&
             (((ld_r[3] > ld_r[0]) && (fq_r[3] >= fq_r[0])) ||
              ((ld_r[3] > ld_r[1]) && (fq_r[3] >= fq_r[1]))));
    tgt    = child;
    lowest = chp_pkg::FULL_LOAD;
    if (online_r[2] && (ld_r[2] < lowest)) begin
      tgt    = 2'd2;
      lowest = ld_r[2];
    end
    if (online_r[3] && (ld_r[3] < lowest)) begin
      tgt = 2'd3;
    end

    if (cmd.sum) begin
      sum_nxt = (online_r[0] ? {2'b00, ld_r[0]} : '0) +
                (online_r[1] ? {2'b00, ld_r[1]} : '0) +
                (online_r[2] ? {2'b00, ld_r[2]} : '0) +
                (online_r[3] ? {2'b00, ld_r[3]} : '0);
      n_nxt   = CNT_ones(online_r);
    end

    if (cmd.cnt) begin
      if (boost_en_r && (ld_p >= chp_pkg::FULL_LOAD) && avg_full) begin
        if (up_ok_child) begin
          online_nxt[child] = 1'b1;
          last_nxt          = now_r;
        end
      end else if ((ld_p >= single_thr_r) && avg_ok &&
                   (press_p < chp_pkg::COUNTER_CAP) && (fq_p >= up_freq_r)) begin
        press_nxt[cmd.part] = press_p + 5'd2;
      end else if (press_p != '0) begin
        press_nxt[cmd.part] = press_p - 5'd1;
      end
    end

    if (cmd.dec) begin
      if (up_hit) begin
        if (up_ok_child) begin
          online_nxt[child] = 1'b1;
          last_nxt          = now_r;
        end
      end else begin
        elapsed_nxt = now_r - last_r;
      end
    end

    if (cmd.down) begin
      // drop the least-loaded child once the hold time has run out, unless skipped or blocked
      if (!diff[chp_pkg::TIME_W-1] && !skip && !block) begin
        online_nxt[tgt] = 1'b0;
        last_nxt        = now_r;
      end
    end

    if (cmd.evt) begin
      unique case (op_r)
        chp_pkg::OP_SCREEN_OFF: begin
          if (saver_en_r) begin
            online_nxt = online_r & 4'b0001;
          end
        end
        chp_pkg::OP_SCREEN_ON: begin
          if (saver_en_r && !online_r[1] && (online_r != chp_pkg::ALL_ONLINE)) begin
            online_nxt[1] = 1'b1;
            last_nxt      = now_r;
          end
          press_nxt[0] = '0;
          press_nxt[1] = '0;
        end
        default: ;
      endcase
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_online_mask = out_online_r;
  assign out_up_mask     = out_up_r;
  assign out_down_mask   = out_down_r;
  assign out_pressure_a  = out_pa_r;
  assign out_pressure_b  = out_pb_r;

endmodule

// ===== hw/rtl/cpu_hotplug_policy_top.sv =====
// Top level of the core hotplug policy block: sequencer plus datapath.
//
// Input channel (in_valid/in_ready): one request per event, carrying the event
// opcode (sample tick, screen off, screen on), the current tick count and the
// load and frequency of all four cores. Result channel (out_valid/out_ready):
// one result per request with the online mask, the cores brought up and taken
// down by that event, and both pressure counters.
// A sample tick walks core 0 and then core 1 through sum, counter update,
// decision and, when onlining is not due, an offline attempt; any other
// event skips the walk. Either way the result register is loaded last.
// A new request is taken only once the previous one has been written to the
// output register, so the block never overlaps requests: the sequencer
// finishes the current request before in_ready rises again.
// A stalled receiver holds the result register; the block finishes the
// current request and then waits with in_ready low until the result drains.
// Reset (rst_n low, synchronous) brings all four cores online, clears both
// counters and the last change time and loads the default thresholds.
// Configuration writes (cfg_wr_en) take effect at the next clock edge.
module cpu_hotplug_policy_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [chp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [chp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [chp_pkg::OP_W-1:0]          in_opcode,
  input  logic [chp_pkg::TIME_W-1:0]        in_now_ticks,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c0,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c1,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c2,
  input  logic [chp_pkg::LOAD_W-1:0]        in_load_c3,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c0,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c1,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c2,
  input  logic [chp_pkg::FREQ_W-1:0]        in_freq_c3,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [chp_pkg::NUM_CORES-1:0]     out_online_mask,
  output logic [chp_pkg::NUM_CORES-1:0]     out_up_mask,
  output logic [chp_pkg::NUM_CORES-1:0]     out_down_mask,
  output logic [chp_pkg::PRESS_W-1:0]       out_pressure_a,
  output logic [chp_pkg::PRESS_W-1:0]       out_pressure_b
);

  chp_pkg::cmd_t cmd;
  chp_pkg::sts_t sts;

  chp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_now_ticks    (in_now_ticks),
    .in_load_c0      (in_load_c0),
    .in_load_c1      (in_load_c1),
    .in_load_c2      (in_load_c2),
    .in_load_c3      (in_load_c3),
    .in_freq_c0      (in_freq_c0),
    .in_freq_c1      (in_freq_c1),
    .in_freq_c2      (in_freq_c2),
    .in_freq_c3      (in_freq_c3),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_online_mask (out_online_mask),
    .out_up_mask     (out_up_mask),
    .out_down_mask   (out_down_mask),
    .out_pressure_a  (out_pressure_a),
    .out_pressure_b  (out_pressure_b)
  );

endmodule

// ===== bench/cpu_hotplug_policy_checker.sv =====
// Checker for the core hotplug policy block: predicts each event's decision and compares.
module cpu_hotplug_policy_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [chp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [chp_pkg::OP_W-1:0]        in_opcode,
  input  logic [chp_pkg::TIME_W-1:0]      in_now_ticks,
  input  logic [chp_pkg::LOAD_W-1:0]      in_load_c0,
  input  logic [chp_pkg::LOAD_W-1:0]      in_load_c1,
  input  logic [chp_pkg::LOAD_W-1:0]      in_load_c2,
  input  logic [chp_pkg::LOAD_W-1:0]      in_load_c3,
  input  logic [chp_pkg::FREQ_W-1:0]      in_freq_c0,
  input  logic [chp_pkg::FREQ_W-1:0]      in_freq_c1,
  input  logic [chp_pkg::FREQ_W-1:0]      in_freq_c2,
  input  logic [chp_pkg::FREQ_W-1:0]      in_freq_c3,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [chp_pkg::NUM_CORES-1:0]   out_online_mask,
  input  logic [chp_pkg::NUM_CORES-1:0]   out_up_mask,
  input  logic [chp_pkg::NUM_CORES-1:0]   out_down_mask,
  input  logic [chp_pkg::PRESS_W-1:0]     out_pressure_a,
  input  logic [chp_pkg::PRESS_W-1:0]     out_pressure_b,
  output int                              fail_count,
  output int                              pending
);
  import chp_pkg::*;

  typedef struct packed {
    logic [NUM_CORES-1:0] online;
    logic [NUM_CORES-1:0] up;
    logic [NUM_CORES-1:0] down;
    logic [PRESS_W-1:0]   press_a;
    logic [PRESS_W-1:0]   press_b;
  } decision_t;

  // shadow registers
  logic [LOAD_W-1:0]    single_thr;
  logic [LOAD_W-1:0]    avg_thr;
  logic [FREQ_W-1:0]    up_freq;
  logic                 boost_en;
  logic                 saver_en;
  logic [HOLD_W-1:0]    hold_ticks;

  // policy state
  logic [NUM_CORES-1:0] online;
  logic [PRESS_W-1:0]   press [2];
  logic [TIME_W-1:0]    last_chg;

  // fields of the event under evaluation
  logic [LOAD_W-1:0]    load_v [NUM_CORES];
  logic [FREQ_W-1:0]    freq_v [NUM_CORES];
  logic [TIME_W-1:0]    now_v;

  decision_t            decisions_q [$];
  decision_t            want;
  int                   fails = 0;

  function automatic logic core_on(int c);
    if (c < 0 || c >= NUM_CORES) return 1'b0;
    return online[c];
  endfunction

  function automatic int cores_on();
    int n;
    n = 0;
    for (int c = 0; c < NUM_CORES; c++) n += online[c] ? 1 : 0;
    return n;
  endfunction

  function automatic int mean_load();
    int sum;
    int n;
    sum = 0;
    n = cores_on();
    for (int c = 0; c < NUM_CORES; c++) if (online[c]) sum += load_v[c];
    return (n != 0) ? sum / n : 0;
  endfunction

  function automatic void bring_online(int c);
    if (!online[c] && cores_on() != NUM_CORES) begin
      online[c] = 1'b1;
      last_chg = now_v;
    end
  endfunction

  function automatic void try_offline(int c);
    logic [TIME_W-1:0] since;
    logic [LOAD_W-1:0] lowest;
    int                victim;
    since = now_v - last_chg - hold_ticks;
    lowest = FULL_LOAD;
    victim = c;
    // signed wrapping compare: still inside the hold window
    if (since[TIME_W-1]) return;
    if (!core_on(c) && (!core_on(c + 1) || !core_on(c - 1))) return;
    for (int j = 2; j < 4; j++) begin
      if (online[j]) begin
        // a child busier and at least as fast as a parent blocks the attempt
        for (int i = 0; i < 2; i++)
          if (load_v[j] > load_v[i] && freq_v[j] >= freq_v[i]) return;
        if (load_v[j] < lowest) begin
          lowest = load_v[j];
          victim = j;
        end
      end
    end
    online[victim] = 1'b0;
    last_chg = now_v;
  endfunction

  function automatic void step_counter(int p);
    int avg;
    avg = mean_load();
    if (boost_en && load_v[p] >= FULL_LOAD && avg >= FULL_LOAD) begin
      bring_online(p + 2);
      return;
    end
    if (load_v[p] >= single_thr && avg >= avg_thr && press[p] < COUNTER_CAP &&
        freq_v[p] >= up_freq)
      press[p] = press[p] + 2;
    else if (press[p] != 0)
      press[p] = press[p] - 1;
  endfunction

  function automatic decision_t decide_event(logic [OP_W-1:0] op);
    logic [NUM_CORES-1:0] prior;
    decision_t            d;
    prior = online;
    case (op)
      OP_TICK: begin
        for (int p = 0; p < 2; p++) begin
          step_counter(p);
          if (press[p] >= UP_LEVEL) bring_online(p + 2);
          else try_offline(p + 2);
        end
      end
      OP_SCREEN_OFF: if (saver_en) online = online & 4'b0001;
      OP_SCREEN_ON: begin
        if (saver_en) bring_online(1);
        press[0] = '0;
        press[1] = '0;
      end
      default: ;
    endcase
    d.online  = online;
    d.up      = online & ~prior;
    d.down    = prior & ~online;
    d.press_a = press[0];
    d.press_b = press[1];
    return d;
  endfunction

  function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, what, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      single_thr = RST_SINGLE_THR;
      avg_thr    = RST_AVG_THR;
      up_freq    = RST_UP_FREQ;
      boost_en   = RST_BOOST_EN;
      saver_en   = RST_SAVER_EN;
      hold_ticks = RST_HOLD_TICKS;
      online     = ALL_ONLINE;
      press[0]   = '0;
      press[1]   = '0;
      last_chg   = '0;
      decisions_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SINGLE_THR: single_thr = cfg_wdata[LOAD_W-1:0];
          CFG_AVG_THR:    avg_thr    = cfg_wdata[LOAD_W-1:0];
          CFG_UP_FREQ:    up_freq    = cfg_wdata[FREQ_W-1:0];
          CFG_BOOST_EN:   boost_en   = cfg_wdata[0];
          CFG_SAVER_EN:   saver_en   = cfg_wdata[0];
          CFG_HOLD_TICKS: hold_ticks = cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting so a same-edge request lands behind
      if (out_valid && out_ready) begin
        if (decisions_q.size() == 0) begin
          $display("%0t: unexpected result: expected none actual online %0h", $time,
                   out_online_mask);
          fails++;
        end else begin
          want = decisions_q.pop_front();
          check_field("online_mask", want.online, out_online_mask);
          check_field("up_mask", want.up, out_up_mask);
          check_field("down_mask", want.down, out_down_mask);
          check_field("pressure_a", want.press_a, out_pressure_a);
          check_field("pressure_b", want.press_b, out_pressure_b);
        end
      end
      if (in_valid && in_ready) begin
        now_v     = in_now_ticks;
        load_v[0] = in_load_c0;
        load_v[1] = in_load_c1;
        load_v[2] = in_load_c2;
        load_v[3] = in_load_c3;
        freq_v[0] = in_freq_c0;
        freq_v[1] = in_freq_c1;
        freq_v[2] = in_freq_c2;
        freq_v[3] = in_freq_c3;
        decisions_q.push_back(decide_event(in_opcode));
      end
    end
    fail_count <= fails;
    pending    <= decisions_q.size();
  end

endmodule

// ===== bench/tb_cpu_hotplug_policy_top.sv =====
// Testbench top for the core hotplug policy block: stimulus, idling and verdict.
module tb_cpu_hotplug_policy_top;
  import chp_pkg::*;

  localparam int                IDLE_LIMIT = 4000;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;
  localparam logic [LOAD_W-1:0] LOAD_MAX   = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [TIME_W-1:0]     in_now_ticks = '0;
  logic [LOAD_W-1:0]     in_load_c0 = '0;
  logic [LOAD_W-1:0]     in_load_c1 = '0;
  logic [LOAD_W-1:0]     in_load_c2 = '0;
  logic [LOAD_W-1:0]     in_load_c3 = '0;
  logic [FREQ_W-1:0]     in_freq_c0 = '0;
  logic [FREQ_W-1:0]     in_freq_c1 = '0;
  logic [FREQ_W-1:0]     in_freq_c2 = '0;
  logic [FREQ_W-1:0]     in_freq_c3 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [NUM_CORES-1:0]  out_online_mask;
  logic [NUM_CORES-1:0]  out_up_mask;
  logic [NUM_CORES-1:0]  out_down_mask;
  logic [PRESS_W-1:0]    out_pressure_a;
  logic [PRESS_W-1:0]    out_pressure_b;
  int                    fail_count;
  int                    pending;

  // what the stimulus currently believes about the block's settings
  logic [FREQ_W-1:0]     up_freq_set = RST_UP_FREQ;
  logic [HOLD_W-1:0]     hold_set = RST_HOLD_TICKS;
  logic [TIME_W-1:0]     clock_now = '0;

  int                    idle_cycles = 0;
  logic [7:0]            ready_cnt = '0;
  int                    ready_style = 0;

  cpu_hotplug_policy_top DUT (.*);

  cpu_hotplug_policy_checker u_policy_chk (.*);

  always #1 clk = ~clk;

  // receiver: pick a new stall style each time the 8-bit ready_cnt wraps
  always @(posedge clk) begin
    if (ready_cnt == 0) ready_style <= $urandom % 4;
    ready_cnt <= ready_cnt + 1;
    case (ready_style)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom % 2;
      2: out_ready <= ($urandom % 4) == 0;
      default: out_ready <= (ready_cnt % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_cpu_hotplug_policy_top failed");
      $finish;
    end
  end

  // present one request and hold it until accepted; returns on the accepting edge
  task automatic send_event(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                            input logic [LOAD_W-1:0] l0, l1, l2, l3,
                            input logic [FREQ_W-1:0] f0, f1, f2, f3);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_now_ticks <= now;
    in_load_c0   <= l0;
    in_load_c1   <= l1;
    in_load_c2   <= l2;
    in_load_c3   <= l3;
    in_freq_c0   <= f0;
    in_freq_c1   <= f1;
    in_freq_c2   <= f2;
    in_freq_c3   <= f3;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold the sender until every expected result has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic configure(input logic [LOAD_W-1:0] single, input logic [LOAD_W-1:0] avg,
                           input logic [FREQ_W-1:0] upf, input logic boost,
                           input logic saver, input logic [HOLD_W-1:0] hold);
    write_reg(CFG_SINGLE_THR, single);
    write_reg(CFG_AVG_THR, avg);
    write_reg(CFG_UP_FREQ, upf);
    write_reg(CFG_BOOST_EN, boost);
    write_reg(CFG_SAVER_EN, saver);
    write_reg(CFG_HOLD_TICKS, hold);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    up_freq_set = upf;
    hold_set = hold;
  endtask

  // mode 0: heavy load, mode 1: light load, otherwise anything the fields allow
  task automatic random_event(input int mode);
    logic [OP_W-1:0]   op;
    logic [LOAD_W-1:0] l [NUM_CORES];
    logic [FREQ_W-1:0] f [NUM_CORES];
    int                r;
    r = $urandom % 100;
    op = (r < 84) ? OP_TICK : (r < 91) ? OP_SCREEN_OFF : (r < 98) ? OP_SCREEN_ON : OP_UNUSED;
    if ($urandom % 20 == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, hold_set + hold_set / 2 + 8);
    for (int c = 0; c < NUM_CORES; c++) begin
      case (mode)
        0: begin
          if (c < 2 || $urandom % 2 == 0) l[c] = $urandom_range(85, LOAD_MAX);
          else l[c] = $urandom_range(0, LOAD_MAX);
          if ($urandom % 4 == 0) l[c] = FULL_LOAD;
          f[c] = $urandom_range(up_freq_set, FREQ_MAX);
        end
        1: begin
          l[c] = $urandom_range(0, 60);
          f[c] = $urandom_range(0, FREQ_MAX);
        end
        default: begin
          l[c] = $urandom;
          f[c] = $urandom;
        end
      endcase
    end
    send_event(op, clock_now, l[0], l[1], l[2], l[3], f[0], f[1], f[2], f[3]);
  endtask

  initial begin
    int                sent;
    int                burst;
    int                mode;
    logic [LOAD_W-1:0] single;
    logic [LOAD_W-1:0] avg;
    logic [FREQ_W-1:0] upf;
    logic [HOLD_W-1:0] hold;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings; the first tick falls inside the hold window
    send_event(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_event(OP_UNUSED, 7, LOAD_MAX, LOAD_MAX, LOAD_MAX, LOAD_MAX,
               FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX);
    // saturate both counters: children drop, come back at the up level, counters hit the cap
    clock_now = 200;
    repeat (13) begin
      send_event(OP_TICK, clock_now, LOAD_MAX, LOAD_MAX, LOAD_MAX, LOAD_MAX,
                 FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX);
      clock_now = clock_now + 150;
    end
    send_event(OP_SCREEN_ON, clock_now, 0, 0, 0, 0, 0, 0, 0, 0);
    // children busier and faster than parents block offlining
    send_event(OP_TICK, clock_now + 1000, 20, 20, 90, 90, 500000, 500000, FREQ_MAX, FREQ_MAX);
    // least-loaded child goes offline
    send_event(OP_TICK, clock_now + 2000, 60, 60, 30, 10, FREQ_MAX, FREQ_MAX, 0, 0);
    send_event(OP_SCREEN_OFF, clock_now + 2100, 0, 0, 0, 0, 0, 0, 0, 0);
    send_event(OP_SCREEN_ON, clock_now + 2200, 0, 0, 0, 0, 0, 0, 0, 0);
    // time wraps past zero
    send_event(OP_TICK, 32'hFFFF_FFF0, 5, 5, 5, 5, 1, 1, 1, 1);
    send_event(OP_TICK, 32'h0000_0020, 5, 5, 5, 5, 1, 1, 1, 1);

    // full load with boost; screen off does nothing with saver disabled
    drain();
    configure(RST_SINGLE_THR, RST_AVG_THR, RST_UP_FREQ, 1'b1, 1'b0, '0);
    send_event(OP_TICK, 32'h100, FULL_LOAD, FULL_LOAD, FULL_LOAD, FULL_LOAD,
               FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX);
    send_event(OP_TICK, 32'h200, FULL_LOAD, FULL_LOAD, FULL_LOAD, FULL_LOAD,
               0, 0, 0, 0);
    send_event(OP_SCREEN_OFF, 32'h300, 0, 0, 0, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: configure('0, '0, '0, 1'b0, 1'b0, '0);
        1: configure(LOAD_MAX, LOAD_MAX, FREQ_MAX, 1'b1, 1'b1, '1);
        2: configure(RST_SINGLE_THR, RST_AVG_THR, RST_UP_FREQ, RST_BOOST_EN, RST_SAVER_EN,
                     RST_HOLD_TICKS);
        default: begin
          single = $urandom_range(40, 100);
          if ($urandom % 6 == 0) single = LOAD_MAX;
          avg = $urandom_range(30, 100);
          upf = $urandom_range(0, 4000000);
          if ($urandom % 6 == 0) upf = FREQ_MAX;
          hold = $urandom_range(0, 400);
          configure(single, avg, upf, $urandom % 2, $urandom % 2, hold);
        end
      endcase
      sent = 0;
      while (sent < 150) begin
        burst = $urandom_range(1, 40);
        mode = $urandom % 3;
        repeat (burst) begin
          random_event(mode);
          sent++;
        end
        if ($urandom % 10 >= 3) idle_sender($urandom_range(1, 12));
        if ($urandom % 25 == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_cpu_hotplug_policy_top passed");
    end else begin
      $display("tb_cpu_hotplug_policy_top failed");
    end
    $finish;
  end

endmodule

// ===== cpu_hotplug_policy_top.f =====
hw/rtl/chp_pkg.sv
hw/rtl/chp_ctrl.sv
hw/rtl/chp_dp.sv
hw/rtl/cpu_hotplug_policy_top.sv
bench/cpu_hotplug_policy_checker.sv
bench/tb_cpu_hotplug_policy_top.sv
